[rtl/core/stepper_command_endstop_controller_assert.svh]
// assertion macros used by the top-level rtl
`ifndef STEPPER_COMMAND_ENDSTOP_CONTROLLER_ASSERT_SVH
`define STEPPER_COMMAND_ENDSTOP_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define SCE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication
`define SCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

[rtl/core/sce_pkg.sv]
// ---------------------------------------------------------------------------
// sce_pkg
// Shared types, codes and reset values of the stepper endstop controller.
// ---------------------------------------------------------------------------
package sce_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_RATE_CONSTANT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_RPM     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_DIVIDER  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LED_HOLD_TICKS  = 3'd4;

   // register reset values
   localparam logic [15:0] RST_RATE_CONSTANT  = 16'd9375;
   localparam logic [7:0]  RST_RELEASE_RPM    = 8'd40;
   localparam logic [3:0]  RST_DEBOUNCE_LIMIT = 4'd10;
   localparam logic [3:0]  RST_SAMPLE_DIVIDER = 4'd10;
   localparam logic [3:0]  RST_LED_HOLD_TICKS = 4'd10;

   // request operations
   localparam logic [1:0] OP_COMMAND     = 2'd0;
   localparam logic [1:0] OP_TIMER_TICK  = 2'd1;
   localparam logic [1:0] OP_SYSTEM_TICK = 2'd2;

   // motor commands
   localparam logic [7:0] CMD_STEP_CW   = 8'd0;
   localparam logic [7:0] CMD_STEP_CCW  = 8'd1;
   localparam logic [7:0] CMD_RUN_CW    = 8'd2;
   localparam logic [7:0] CMD_RUN_CCW   = 8'd3;
   localparam logic [7:0] CMD_STOP      = 8'd4;
   localparam logic [7:0] CMD_POWEROFF  = 8'd5;
   localparam logic [7:0] CMD_RELEASE   = 8'd6;

   // motor status
   localparam logic [1:0] STAT_IDLE = 2'd0;
   localparam logic [1:0] STAT_BUSY = 2'd1;

   localparam logic [3:0] TICK_SAT  = 4'd15;
   localparam logic [7:0] PERIOD_SAT = 8'd255;

   typedef struct packed {
      logic capture;    // latch the accepted request
      logic div_start;  // start the period division
      logic commit;     // apply the request and load the result register
   } sce_cmd_type;

   typedef struct packed {
      logic req_is_cmd; // incoming request is a motor command
      logic div_busy;   // period division still running
   } sce_stat_type;

endpackage

[rtl/core/sce_if.sv]
// ---------------------------------------------------------------------------
// sce_if
// Request and result channels of the stepper endstop controller.
// ---------------------------------------------------------------------------
interface sce_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [7:0]  command_code;
   logic [15:0] step_count;
   logic [7:0]  speed_rpm;
   logic        switch_level;

   modport source (output valid, operation, command_code, step_count, speed_rpm,
                   switch_level, input ready);
   modport sink (input valid, operation, command_code, step_count, speed_rpm,
                 switch_level, output ready);
endinterface

interface sce_rsp_if;
   logic       valid;
   logic       ready;
   logic       step_pulse;
   logic       direction;
   logic       driver_awake;
   logic [1:0] motor_status;
   logic       led_on;
   logic       timer_running;
   logic       command_rejected;

   modport source (output valid, step_pulse, direction, driver_awake, motor_status,
                   led_on, timer_running, command_rejected, input ready);
   modport sink (input valid, step_pulse, direction, driver_awake, motor_status,
                 led_on, timer_running, command_rejected, output ready);
endinterface

[rtl/core/sce_div.sv]
// ---------------------------------------------------------------------------
// sce_div
// Restoring divider, 16-bit dividend by 8-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module sce_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [7:0]  dvs_ff, dvs_in;
   logic [8:0]  trial;
   logic [8:0]  diff;
   logic        fits;

   assign trial = {rem_ff, quo_ff[15]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[14:0], fits};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/sce_datapath.sv]
// ---------------------------------------------------------------------------
// sce_datapath
// Configuration registers, motor and endstop state, result register.
// ---------------------------------------------------------------------------
module sce_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [sce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sce_pkg::CSR_DATA_W-1:0]  csr_write_data,
   input  logic [1:0]                     req_operation,
   input  logic [7:0]                     req_command_code,
   input  logic [15:0]                    req_step_count,
   input  logic [7:0]                     req_speed_rpm,
   input  logic                           req_switch_level,
   input  sce_pkg::sce_cmd_type           cmd,
   output logic                           req_is_cmd,
   output logic [15:0]                    div_dividend,
   output logic [7:0]                     div_divisor,
   input  logic [15:0]                    div_quotient,
   output logic                           rsp_step_pulse,
   output logic                           rsp_direction,
   output logic                           rsp_driver_awake,
   output logic [1:0]                     rsp_motor_status,
   output logic                           rsp_led_on,
   output logic                           rsp_timer_running,
   output logic                           rsp_command_rejected
);
   import sce_pkg::*;

   // configuration
   logic [15:0] rate_ff;
   logic [7:0]  rel_rpm_ff;
   logic [3:0]  deb_lim_ff, smp_div_ff, led_hold_ff;

   // latched request
   logic [1:0]  op_ff;
   logic [7:0]  code_ff;
   logic [15:0] steps_ff;
   logic [7:0]  rpm_ff;
   logic        level_ff;

   // motor state
   logic [15:0] steps_left_ff, steps_left_in;
   logic        free_run_ff, free_run_in;
   logic        dir_ff, dir_in;
   logic        awake_ff, awake_in;
   logic        fstop_ff, fstop_in;
   logic        frel_ff, frel_in;
   logic        inval_ff, inval_in;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  period_ff, period_in;
   logic [7:0]  pcount_ff, pcount_in;
   logic        timer_on_ff, timer_on_in;
   logic [3:0]  press_ff, press_in;
   logic [3:0]  relcnt_ff, relcnt_in;
   logic [3:0]  sdc_ff, sdc_in;
   logic [3:0]  led_tmr_ff, led_tmr_in;
   logic        led_ff, led_in;
   logic        pulse;
   logic [7:0]  period_q;

   // result register
   logic        o_pulse_ff;
   logic        o_dir_ff;
   logic        o_awake_ff;
   logic [1:0]  o_status_ff;
   logic        o_led_ff;
   logic        o_timer_ff;
   logic        o_inval_ff;

   assign req_is_cmd   = (req_operation == OP_COMMAND);
   assign div_dividend = rate_ff;
   // release while force-stopped backs off at the release speed
   assign div_divisor  = (fstop_ff && req_command_code == CMD_RELEASE) ? rel_rpm_ff
                                                                       : req_speed_rpm;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= RST_RATE_CONSTANT;
         rel_rpm_ff  <= RST_RELEASE_RPM;
         deb_lim_ff  <= RST_DEBOUNCE_LIMIT;
         smp_div_ff  <= RST_SAMPLE_DIVIDER;
         led_hold_ff <= RST_LED_HOLD_TICKS;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_RATE_CONSTANT:  rate_ff     <= csr_write_data;
            REG_RELEASE_RPM:    rel_rpm_ff  <= csr_write_data[7:0];
            REG_DEBOUNCE_LIMIT: deb_lim_ff  <= csr_write_data[3:0];
            REG_SAMPLE_DIVIDER: smp_div_ff  <= csr_write_data[3:0];
            REG_LED_HOLD_TICKS: led_hold_ff <= csr_write_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         code_ff  <= req_command_code;
         steps_ff <= req_step_count;
         rpm_ff   <= div_divisor;
         level_ff <= req_switch_level;
      end
   end

   // saturated step period
   always_comb begin
      if (rpm_ff == 8'd0 || div_quotient[15:8] != 8'd0) begin
         period_q = PERIOD_SAT;
      end else begin
         period_q = div_quotient[7:0];
      end
   end

   always_comb begin
      steps_left_in = steps_left_ff;
      free_run_in   = free_run_ff;
      dir_in        = dir_ff;
      awake_in      = awake_ff;
      fstop_in      = fstop_ff;
      frel_in       = frel_ff;
      inval_in      = inval_ff;
      status_in     = status_ff;
      period_in     = period_ff;
      pcount_in     = pcount_ff;
      timer_on_in   = timer_on_ff;
      press_in      = press_ff;
      relcnt_in     = relcnt_ff;
      sdc_in        = sdc_ff;
      led_tmr_in    = led_tmr_ff;
      led_in        = led_ff;
      pulse         = 1'b0;

      case (op_ff)
         OP_COMMAND: begin
            if (!fstop_ff) begin
               if (code_ff inside {CMD_STEP_CW, CMD_STEP_CCW, CMD_RUN_CW, CMD_RUN_CCW}) begin
                  awake_in      = 1'b1;
                  dir_in        = ~code_ff[0];
                  free_run_in   = code_ff[1];
                  steps_left_in = code_ff[1] ? 16'd0 : steps_ff;
                  inval_in      = 1'b0;
               end else if (code_ff inside {CMD_STOP, CMD_POWEROFF}) begin
                  steps_left_in = '0;
                  free_run_in   = 1'b0;
                  timer_on_in   = 1'b0;
                  awake_in      = (code_ff == CMD_STOP);
                  inval_in      = 1'b0;
               end else begin
                  inval_in = 1'b1;
               end
            end else if (code_ff == CMD_RELEASE) begin
               dir_in  = ~dir_ff;
               frel_in = 1'b1;
            end
            if (!inval_in) begin
               status_in   = STAT_BUSY;
               led_in      = 1'b1;
               led_tmr_in  = '0;
               period_in   = period_q;
               pcount_in   = '0;
               timer_on_in = 1'b1;
            end
         end
         OP_TIMER_TICK: begin
            if (timer_on_ff) begin
               if (pcount_ff < period_ff) begin
                  pcount_in = pcount_ff + 8'd1;
               end else begin
                  pcount_in = '0;
                  if (fstop_ff) begin
                     steps_left_in = '0;
                     free_run_in   = 1'b0;
                     if (frel_ff) begin
                        pulse = 1'b1;
                     end else begin
                        timer_on_in = 1'b0;
                     end
                  end else if (free_run_ff) begin
                     pulse = 1'b1;
                  end else if (steps_left_ff != 16'd0) begin
                     steps_left_in = steps_left_ff - 16'd1;
                     pulse         = 1'b1;
                  end else begin
                     status_in   = STAT_IDLE;
                     timer_on_in = 1'b0;
                  end
               end
            end
         end
         OP_SYSTEM_TICK: begin
            if (led_tmr_ff < TICK_SAT) begin
               led_tmr_in = led_tmr_ff + 4'd1;
            end
            if (sdc_ff < TICK_SAT) begin
               sdc_in = sdc_ff + 4'd1;
            end
            if (sdc_in >= smp_div_ff) begin
               if (level_ff && press_ff < deb_lim_ff) begin
                  press_in = press_ff + 4'd1;
               end else if (!level_ff && relcnt_ff < deb_lim_ff) begin
                  relcnt_in = relcnt_ff + 4'd1;
               end
               sdc_in = '0;
            end
         end
         default: ;
      endcase

      // debounce outcome, release count wins
      if (relcnt_in >= deb_lim_ff) begin
         led_in    = 1'b0;
         press_in  = '0;
         relcnt_in = '0;
         fstop_in  = 1'b0;
         frel_in   = 1'b0;
         if (status_in[1]) begin
            status_in = STAT_IDLE;
         end
      end else if (press_in >= deb_lim_ff) begin
         led_in     = 1'b1;
         fstop_in   = 1'b1;
         led_tmr_in = '0;
         status_in  = {1'b1, dir_in};
      end
      if (led_tmr_in >= led_hold_ff) begin
         led_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff <= '0;
         free_run_ff   <= 1'b0;
         dir_ff        <= 1'b1;
         awake_ff      <= 1'b1;
         fstop_ff      <= 1'b0;
         frel_ff       <= 1'b0;
         inval_ff      <= 1'b0;
         status_ff     <= STAT_IDLE;
         period_ff     <= '0;
         pcount_ff     <= '0;
         timer_on_ff   <= 1'b0;
         press_ff      <= '0;
         relcnt_ff     <= '0;
         sdc_ff        <= '0;
         led_tmr_ff    <= '0;
         led_ff        <= 1'b0;
      end else if (cmd.commit) begin
         steps_left_ff <= steps_left_in;
         free_run_ff   <= free_run_in;
         dir_ff        <= dir_in;
         awake_ff      <= awake_in;
         fstop_ff      <= fstop_in;
         frel_ff       <= frel_in;
         inval_ff      <= inval_in;
         status_ff     <= status_in;
         period_ff     <= period_in;
         pcount_ff     <= pcount_in;
         timer_on_ff   <= timer_on_in;
         press_ff      <= press_in;
         relcnt_ff     <= relcnt_in;
         sdc_ff        <= sdc_in;
         led_tmr_ff    <= led_tmr_in;
         led_ff        <= led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_pulse_ff  <= pulse;
         o_dir_ff    <= dir_in;
         o_awake_ff  <= awake_in;
         o_status_ff <= status_in;
         o_led_ff    <= led_in;
         o_timer_ff  <= timer_on_in;
         o_inval_ff  <= inval_in;
      end
   end

   assign rsp_step_pulse       = o_pulse_ff;
   assign rsp_direction        = o_dir_ff;
   assign rsp_driver_awake     = o_awake_ff;
   assign rsp_motor_status     = o_status_ff;
   assign rsp_led_on           = o_led_ff;
   assign rsp_timer_running    = o_timer_ff;
   assign rsp_command_rejected = o_inval_ff;
endmodule

[rtl/core/sce_ctrl.sv]
// ---------------------------------------------------------------------------
// sce_ctrl
// Sequencer: accepts a request, waits on the divider for commands, commits the result.
// ---------------------------------------------------------------------------
module sce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sce_pkg::sce_stat_type stat,
   output sce_pkg::sce_cmd_type  cmd
);
   import sce_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DIV   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // result register must be free or draining this cycle
   assign commit    = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = stat.req_is_cmd ? ST_DIV : ST_APPLY;
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.capture   = accept;
   assign cmd.div_start = accept && stat.req_is_cmd;
   assign cmd.commit    = commit;
   assign rsp_valid     = rsp_valid_ff;
endmodule

[rtl/core/stepper_command_endstop_controller.sv]
// Sequence: timer and system ticks go from acceptance through the apply state to
// the result register; commands first wait on the bit-serial period divider.
// Flow: one request at a time; the apply state also waits while the result
// register holds a result that rsp_chan.ready has not yet taken.
// Reset: synchronous, active high; loads register defaults and resets motor state.
// ---------------------------------------------------------------------------
// stepper_command_endstop_controller
// Stepper driver controller with step timer, endstop debounce and activity LED.
// ---------------------------------------------------------------------------
module stepper_command_endstop_controller (
   input  logic                            clock,
   input  logic                            reset,
   sce_req_if.sink                         req_chan,
   sce_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [sce_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sce_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import sce_pkg::*;

   sce_cmd_type  ctrl_cmd;
   sce_stat_type ctrl_stat;
   logic         req_is_cmd;
   logic         div_busy;
   logic [15:0]  div_dividend;
   logic [7:0]   div_divisor;
   logic [15:0]  div_quotient;

   assign ctrl_stat.req_is_cmd = req_is_cmd;
   assign ctrl_stat.div_busy   = div_busy;

   sce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (ctrl_stat),
      .cmd       (ctrl_cmd)
   );

   sce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl_cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   sce_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_operation        (req_chan.operation),
      .req_command_code     (req_chan.command_code),
      .req_step_count       (req_chan.step_count),
      .req_speed_rpm        (req_chan.speed_rpm),
      .req_switch_level     (req_chan.switch_level),
      .cmd                  (ctrl_cmd),
      .req_is_cmd           (req_is_cmd),
      .div_dividend         (div_dividend),
      .div_divisor          (div_divisor),
      .div_quotient         (div_quotient),
      .rsp_step_pulse       (rsp_chan.step_pulse),
      .rsp_direction        (rsp_chan.direction),
      .rsp_driver_awake     (rsp_chan.driver_awake),
      .rsp_motor_status     (rsp_chan.motor_status),
      .rsp_led_on           (rsp_chan.led_on),
      .rsp_timer_running    (rsp_chan.timer_running),
      .rsp_command_rejected (rsp_chan.command_rejected)
   );

`include "stepper_command_endstop_controller_assert.svh"

   // one request in flight at a time
   `SCE_ASSERT_NEXT(a_one_in_flight, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready)
   // a commit never overwrites a result that is not taken
   `SCE_ASSERT_NOW(a_no_overwrite, clock, reset,
      ctrl_cmd.commit, !rsp_chan.valid || rsp_chan.ready)
   // the divider only starts on an accepted command
   `SCE_ASSERT_NOW(a_div_on_cmd, clock, reset,
      ctrl_cmd.div_start, req_chan.valid && req_chan.ready && !div_busy)
   // a commit is never issued while the divider runs
   `SCE_ASSERT_NOW(a_commit_after_div, clock, reset,
      ctrl_cmd.commit, !div_busy)

endmodule
